/* design/ale_pkg.sv */
// shared types and codes for the array list engine
package ale_pkg;

    // operation codes
    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_DELETE = 3'd2;
    localparam logic [2:0] OP_LOCATE = 3'd3;
    localparam logic [2:0] OP_SORTED = 3'd4;
    localparam logic [2:0] OP_READ   = 3'd5;

    // result status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_REJECT    = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // pointer update modes
    localparam logic [2:0] PTR_HOLD = 3'd0;
    localparam logic [2:0] PTR_LEN  = 3'd1;
    localparam logic [2:0] PTR_POS  = 3'd2;
    localparam logic [2:0] PTR_ZERO = 3'd3;
    localparam logic [2:0] PTR_INC  = 3'd4;
    localparam logic [2:0] PTR_DEC  = 3'd5;

    // read address modes
    localparam logic [1:0] RD_PTR  = 2'd0;
    localparam logic [1:0] RD_PREV = 2'd1;
    localparam logic [1:0] RD_NEXT = 2'd2;

    // length update modes
    localparam logic [1:0] LEN_HOLD  = 2'd0;
    localparam logic [1:0] LEN_CLEAR = 2'd1;
    localparam logic [1:0] LEN_INC   = 2'd2;
    localparam logic [1:0] LEN_DEC   = 2'd3;

    // request item
    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] value;
        logic [4:0]         position;
    } req_item_t;

    // response item
    typedef struct packed {
        logic [1:0]         status;
        logic [3:0]         index;
        logic signed [31:0] read_value;
        logic [4:0]         entry_count;
    } rsp_item_t;

    // how a finished item is written back
    typedef struct packed {
        logic [1:0] status;
        logic [1:0] len_mode;
        logic       idx_ptr;
        logic       use_rdata;
    } fin_t;

    // controller to datapath commands
    typedef struct packed {
        logic       load;
        logic [2:0] ptr_mode;
        logic       mem_rd;
        logic [1:0] rd_mode;
        logic       mem_wr;
        logic       wr_rdata;
        logic       res_load;
        fin_t       fin;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [2:0] op;
        logic       pos_le_len;
        logic       pos_lt_len;
        logic       full;
        logic       ptr_eq_pos;
        logic       ptr_eq_len;
        logic       ptr_zero;
        logic       ptr_last;
        logic       match;
        logic       greater;
        logic       out_free;
    } sts_t;

endpackage

/* design/ale_dpath.sv */
// datapath of the array list engine: entry memory, pointer, length, response register
module ale_dpath
    import ale_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  req_item_t req,
    input  cmd_t      cmd,
    output sts_t      sts,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    localparam int PW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = (PW > 5) ? PW : 5;

    logic [2:0]         op_reg;
    logic signed [31:0] val_reg;
    logic [4:0]         pos_reg;
    logic [PW-1:0]      len_reg;
    logic [PW-1:0]      len_next;
    logic [PW-1:0]      ptr_reg;
    logic [PW-1:0]      ptr_next;
    logic [PW-1:0]      ptr_plus;
    logic [PW-1:0]      ptr_minus;
    logic [PW-1:0]      rd_sel;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;
    logic signed [31:0] rdata_reg;
    logic signed [31:0] mem [CAPACITY];
    logic               rsp_valid_reg;
    rsp_item_t          rsp_reg;
    rsp_item_t          rsp_next;
    logic [CW-1:0]      pos_ext;
    logic [CW-1:0]      len_ext;
    logic [CW-1:0]      ptr_ext;
    logic [PW+3:0]      ptr_wide;
    logic [PW+4:0]      len_wide;

    // comparisons for the controller
    assign pos_ext   = CW'(pos_reg);
    assign len_ext   = CW'(len_reg);
    assign ptr_ext   = CW'(ptr_reg);
    assign ptr_plus  = ptr_reg + PW'(1);
    assign ptr_minus = ptr_reg - PW'(1);

    always_comb
    begin
        sts.op         = op_reg;
        sts.pos_le_len = pos_ext <= len_ext;
        sts.pos_lt_len = pos_ext < len_ext;
        sts.full       = len_reg == PW'(CAPACITY);
        sts.ptr_eq_pos = ptr_ext == pos_ext;
        sts.ptr_eq_len = ptr_reg == len_reg;
        sts.ptr_zero   = ptr_reg == '0;
        sts.ptr_last   = ptr_plus == len_reg;
        sts.match      = rdata_reg == val_reg;
        sts.greater    = rdata_reg > val_reg;
        sts.out_free   = !rsp_valid_reg || !rsp_stall;
    end

    // pointer update
    always_comb
    begin
        case (cmd.ptr_mode)
            PTR_LEN:  ptr_next = len_reg;
            PTR_POS:  ptr_next = pos_ext[PW-1:0];
            PTR_ZERO: ptr_next = '0;
            PTR_INC:  ptr_next = ptr_plus;
            PTR_DEC:  ptr_next = ptr_minus;
            default:  ptr_next = ptr_reg;
        endcase
    end

    // memory addresses and write data
    always_comb
    begin
        case (cmd.rd_mode)
            RD_PREV: rd_sel = ptr_minus;
            RD_NEXT: rd_sel = ptr_plus;
            default: rd_sel = ptr_reg;
        endcase
    end

    assign rd_addr = rd_sel[AW-1:0];
    assign wr_addr = ptr_reg[AW-1:0];
    assign wr_data = cmd.wr_rdata ? rdata_reg : val_reg;

    // length after the finishing item
    always_comb
    begin
        case (cmd.fin.len_mode)
            LEN_CLEAR: len_next = '0;
            LEN_INC:   len_next = len_reg + PW'(1);
            LEN_DEC:   len_next = len_reg - PW'(1);
            default:   len_next = len_reg;
        endcase
    end

    // response fields, narrowed to their widths
    assign ptr_wide = {4'b0, ptr_reg};
    assign len_wide = {5'b0, len_next};

    always_comb
    begin
        rsp_next.status      = cmd.fin.status;
        rsp_next.index       = cmd.fin.idx_ptr ? ptr_wide[3:0] : 4'd0;
        rsp_next.read_value  = cmd.fin.use_rdata ? rdata_reg : 32'sd0;
        rsp_next.entry_count = len_wide[4:0];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            ptr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            ptr_reg <= ptr_next;
            if (cmd.res_load)
            begin
                len_reg       <= len_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // item and response payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= req.operation;
            val_reg <= req.value;
            pos_reg <= req.position;
        end
        if (cmd.res_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // entry memory, one read and one write port
    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.mem_rd)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* design/ale_ctrl.sv */
// controller state machine of the array list engine
module ale_ctrl
    import ale_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_EV   = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    fin_t       fin_reg;
    fin_t       fin_next;

    assign req_stall = state_reg != S_IDLE;

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        fin_next     = fin_reg;
        cmd          = '0;
        cmd.ptr_mode = PTR_HOLD;
        cmd.rd_mode  = RD_PTR;
        cmd.fin      = fin_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DEC;
                end
            end

            // check the item and set up the walk
            S_DEC:
            begin
                fin_next   = '{ST_REJECT, LEN_HOLD, 1'b0, 1'b0};
                state_next = S_FIN;
                unique case (sts.op)
                    OP_CLEAR:
                    begin
                        fin_next = '{ST_DONE, LEN_CLEAR, 1'b0, 1'b0};
                    end
                    OP_INSERT:
                    begin
                        if (sts.pos_le_len && !sts.full)
                        begin
                            cmd.ptr_mode = PTR_LEN;
                            state_next   = S_CHK;
                        end
                    end
                    OP_DELETE, OP_READ:
                    begin
                        if (sts.pos_lt_len)
                        begin
                            cmd.ptr_mode = PTR_POS;
                            state_next   = S_CHK;
                        end
                    end
                    OP_LOCATE:
                    begin
                        cmd.ptr_mode = PTR_ZERO;
                        state_next   = S_CHK;
                    end
                    OP_SORTED:
                    begin
                        if (!sts.full)
                        begin
                            cmd.ptr_mode = PTR_LEN;
                            state_next   = S_CHK;
                        end
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end

            // end test of the walk, else read the next entry
            S_CHK:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_EV;
                unique case (sts.op)
                    OP_INSERT:
                    begin
                        cmd.rd_mode = RD_PREV;
                        if (sts.ptr_eq_pos)
                        begin
                            cmd.mem_rd = 1'b0;
                            cmd.mem_wr = 1'b1;
                            fin_next   = '{ST_DONE, LEN_INC, 1'b0, 1'b0};
                            state_next = S_FIN;
                        end
                    end
                    OP_DELETE:
                    begin
                        cmd.rd_mode = RD_NEXT;
                        if (sts.ptr_last)
                        begin
                            cmd.mem_rd = 1'b0;
                            fin_next   = '{ST_DONE, LEN_DEC, 1'b0, 1'b0};
                            state_next = S_FIN;
                        end
                    end
                    OP_LOCATE:
                    begin
                        if (sts.ptr_eq_len)
                        begin
                            cmd.mem_rd = 1'b0;
                            fin_next   = '{ST_NOT_FOUND, LEN_HOLD, 1'b0, 1'b0};
                            state_next = S_FIN;
                        end
                    end
                    OP_SORTED:
                    begin
                        cmd.rd_mode = RD_PREV;
                        if (sts.ptr_zero)
                        begin
                            cmd.mem_rd = 1'b0;
                            cmd.mem_wr = 1'b1;
                            fin_next   = '{ST_DONE, LEN_INC, 1'b1, 1'b0};
                            state_next = S_FIN;
                        end
                    end
                    default:
                    begin
                        cmd.rd_mode = RD_PTR;
                    end
                endcase
            end

            // act on the entry just read
            S_EV:
            begin
                state_next = S_CHK;
                unique case (sts.op)
                    OP_INSERT:
                    begin
                        cmd.mem_wr   = 1'b1;
                        cmd.wr_rdata = 1'b1;
                        cmd.ptr_mode = PTR_DEC;
                    end
                    OP_DELETE:
                    begin
                        cmd.mem_wr   = 1'b1;
                        cmd.wr_rdata = 1'b1;
                        cmd.ptr_mode = PTR_INC;
                    end
                    OP_LOCATE:
                    begin
                        if (sts.match)
                        begin
                            fin_next   = '{ST_DONE, LEN_HOLD, 1'b1, 1'b0};
                            state_next = S_FIN;
                        end
                        else
                        begin
                            cmd.ptr_mode = PTR_INC;
                        end
                    end
                    OP_SORTED:
                    begin
                        cmd.mem_wr = 1'b1;
                        if (sts.greater)
                        begin
                            cmd.wr_rdata = 1'b1;
                            cmd.ptr_mode = PTR_DEC;
                        end
                        else
                        begin
                            fin_next   = '{ST_DONE, LEN_INC, 1'b1, 1'b0};
                            state_next = S_FIN;
                        end
                    end
                    default:
                    begin
                        fin_next   = '{ST_DONE, LEN_HOLD, 1'b0, 1'b1};
                        state_next = S_FIN;
                    end
                endcase
            end

            // hand the response over once the output register is free
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fin_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
        end
    end

`ifndef SYNTHESIS
    // an accepted item is decoded in the next cycle
    a_accept_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg == S_DEC))
        else $error("accepted item not decoded");

    // a response is loaded only from the finish state into a free register
    a_res_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> (state_reg == S_FIN && sts.out_free))
        else $error("response loaded out of turn");

    // every memory read is followed by its evaluation
    a_rd_eval: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_rd |=> (state_reg == S_EV))
        else $error("read data not evaluated");

    // the memory is written only while walking the list
    a_wr_walk: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_wr |-> (state_reg == S_CHK || state_reg == S_EV))
        else $error("memory written outside a walk");
`endif

endmodule

/* design/array_list_engine_top.sv */
// top level of the array list engine
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+------------------
//  request | req_valid | req_stall | req  (req_item_t)
//  response| rsp_valid | rsp_stall | rsp  (rsp_item_t)
//
// one item at a time; an item is accepted in the idle state and decoded, then walked
// with a check state and an evaluate state per entry read from the memory, plus a
// closing check when a walk stops at the end of its range instead of on an entry read,
// and then finished; the walk is shaped by the single read port and registered read data.
// reset clears the length and the handshake state; entry words are not cleared.
// a result waits in the output register while rsp_stall is high; the next item
// is already taken and walked, and finishes when that register frees up.
module array_list_engine_top
    import ale_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    cmd_t cmd;
    sts_t sts;

    // sequencer
    ale_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // storage and arithmetic
    ale_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
